// File: rtl/core/bnc_pkg.sv
// Package for the bracket nesting checker: character codes, status codes,
// register indexes, reset weights and the result record type.
// No dependencies.
package bnc_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 128;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SCORE_W  = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [BYTE_W-1:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [BYTE_W-1:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [BYTE_W-1:0] CH_OPEN_ANGLE   = 8'h3C;  // <
  localparam logic [BYTE_W-1:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [BYTE_W-1:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [BYTE_W-1:0] CH_CLOSE_CURLY  = 8'h7D;  // }
  localparam logic [BYTE_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;  // >

  typedef enum logic [KIND_W-1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_ANGLE  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NORMAL   = 2'd0,
    ST_CORRUPT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_SKIPPED  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_ROUND  = 2'd0,
    REG_WEIGHT_SQUARE = 2'd1,
    REG_WEIGHT_CURLY  = 2'd2,
    REG_WEIGHT_ANGLE  = 2'd3
  } reg_idx_t;

  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ROUND  = 16'd3;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_SQUARE = 16'd57;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CURLY  = 16'd1197;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ANGLE  = 16'd25137;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef struct packed {
    status_t            status;
    kind_t              offending_kind;
    logic               line_end;
    logic [COUNT_W-1:0] count_round;
    logic [COUNT_W-1:0] count_square;
    logic [COUNT_W-1:0] count_curly;
    logic [COUNT_W-1:0] count_angle;
    logic [SCORE_W-1:0] total_score;
  } res_t;

endpackage

// File: rtl/core/bracket_nesting_checker_top.sv
// Top level of the bracket nesting checker: opener stack memory, line
// state, corruption counters, score total and a two-entry output stage.
// Depends on bnc_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_ready  in_byte_in
//   out      output     out_valid/out_ready  out_status, out_offending_kind,
//                                            out_line_end, out_count_*,
//                                            out_total_score
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; its result is
// registered in the output register, or in the skid register if the output
// waits. The rate is set by the top-of-stack register and the registered
// read of the entry just below it, refetched every cycle so that a pop finds
// the new top already loaded. Reset is synchronous; the stack memory is not
// cleared, only the level. in_ready depends only on the skid register, so an
// output stall costs one spare slot before the input side stops.
module bracket_nesting_checker_top
  import bnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_byte_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [KIND_W-1:0]    out_offending_kind,
  output logic                 out_line_end,
  output logic [COUNT_W-1:0]   out_count_round,
  output logic [COUNT_W-1:0]   out_count_square,
  output logic [COUNT_W-1:0]   out_count_curly,
  output logic [COUNT_W-1:0]   out_count_angle,
  output logic [SCORE_W-1:0]   out_total_score,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data
);

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADR_W = $clog2(STACK_DEPTH);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
  localparam logic [LVL_W-1:0] LVL_TWO  = LVL_W'(2);

  // Configuration registers.
  logic [WEIGHT_W-1:0] weight_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r[KIND_ROUND]  <= RST_WEIGHT_ROUND;
      weight_r[KIND_SQUARE] <= RST_WEIGHT_SQUARE;
      weight_r[KIND_CURLY]  <= RST_WEIGHT_CURLY;
      weight_r[KIND_ANGLE]  <= RST_WEIGHT_ANGLE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WEIGHT_ROUND:  weight_r[KIND_ROUND]  <= cfg_data;
        REG_WEIGHT_SQUARE: weight_r[KIND_SQUARE] <= cfg_data;
        REG_WEIGHT_CURLY:  weight_r[KIND_CURLY]  <= cfg_data;
        REG_WEIGHT_ANGLE:  weight_r[KIND_ANGLE]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line state. The top of the stack lives in tos_r; below_r holds the
  // entry under it, registered from the stack memory.
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               dead_r, dead_nxt;
  kind_t              tos_r, tos_nxt;
  kind_t              below_r;
  logic [COUNT_W-1:0] count_r [4];
  logic [COUNT_W-1:0] count_nxt [4];
  logic [SCORE_W-1:0] score_r, score_nxt;

  kind_t stack_mem [STACK_DEPTH];

  logic       in_xfer;
  logic       is_nl, is_open, is_close;
  kind_t      open_kind, close_kind;
  logic       do_push, do_pop, do_corrupt;
  status_t    status_w;
  logic [SCORE_W:0]   score_sum;
  logic [LVL_W-1:0]   rd_lvl, rd_lvl_m2;
  logic [ADR_W-1:0]   rd_addr;
  res_t               res_w;

  assign in_xfer = in_valid && in_ready;
  assign is_nl   = (in_byte_in == CH_NEWLINE);

  always_comb begin
    is_open   = 1'b1;
    open_kind = KIND_ROUND;
    unique case (in_byte_in)
      CH_OPEN_ROUND:  open_kind = KIND_ROUND;
      CH_OPEN_SQUARE: open_kind = KIND_SQUARE;
      CH_OPEN_CURLY:  open_kind = KIND_CURLY;
      CH_OPEN_ANGLE:  open_kind = KIND_ANGLE;
      default:        is_open   = 1'b0;
    endcase
  end

  always_comb begin
    is_close   = 1'b1;
    close_kind = KIND_ROUND;
    unique case (in_byte_in)
      CH_CLOSE_ROUND:  close_kind = KIND_ROUND;
      CH_CLOSE_SQUARE: close_kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  close_kind = KIND_CURLY;
      CH_CLOSE_ANGLE:  close_kind = KIND_ANGLE;
      default:         is_close   = 1'b0;
    endcase
  end

  assign score_sum = {1'b0, score_r} + {{(SCORE_W - WEIGHT_W + 1){1'b0}}, weight_r[close_kind]};

  always_comb begin
    level_nxt  = level_r;
    dead_nxt   = dead_r;
    tos_nxt    = tos_r;
    score_nxt  = score_r;
    count_nxt  = count_r;
    status_w   = ST_NORMAL;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_corrupt = 1'b0;
    if (in_xfer) begin
      priority if (is_nl) begin
        level_nxt = '0;
        dead_nxt  = 1'b0;
      end else if (dead_r) begin
        status_w = ST_SKIPPED;
      end else if (is_open) begin
        if (level_r == LVL_FULL) begin
          status_w = ST_OVERFLOW;
          dead_nxt = 1'b1;
        end else begin
          do_push   = 1'b1;
          level_nxt = level_r + LVL_W'(1);
          tos_nxt   = open_kind;
        end
      end else if (is_close) begin
        if (level_r != '0 && tos_r == close_kind) begin
          do_pop    = 1'b1;
          level_nxt = level_r - LVL_W'(1);
          tos_nxt   = below_r;
        end else begin
          do_corrupt = 1'b1;
          status_w   = ST_CORRUPT;
          dead_nxt   = 1'b1;
          if (count_r[close_kind] != COUNT_MAX) begin
            count_nxt[close_kind] = count_r[close_kind] + COUNT_W'(1);
          end
          score_nxt = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
        end
      end else begin
        status_w = ST_NORMAL;
      end
    end
  end

  // Refetch the entry below the top for the level that holds after this
  // cycle. A push writes at the old level while this read is one lower,
  // so the two never meet on the same entry.
  assign rd_lvl    = in_xfer ? level_nxt : level_r;
  assign rd_lvl_m2 = rd_lvl - LVL_TWO;
  assign rd_addr   = (rd_lvl >= LVL_TWO) ? rd_lvl_m2[ADR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[level_r[ADR_W-1:0]] <= open_kind;
    end
    below_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      dead_r  <= 1'b0;
      tos_r   <= KIND_ROUND;
      score_r <= '0;
      for (int k = 0; k < 4; k++) begin
        count_r[k] <= '0;
      end
    end else begin
      level_r <= level_nxt;
      dead_r  <= dead_nxt;
      tos_r   <= tos_nxt;
      score_r <= score_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    res_w.status         = status_w;
    res_w.offending_kind = do_corrupt ? close_kind : KIND_ROUND;
    res_w.line_end       = is_nl;
    res_w.count_round    = count_nxt[KIND_ROUND];
    res_w.count_square   = count_nxt[KIND_SQUARE];
    res_w.count_curly    = count_nxt[KIND_CURLY];
    res_w.count_angle    = count_nxt[KIND_ANGLE];
    res_w.total_score    = score_nxt;
  end

  // Output register plus skid register. The output register always holds
  // the oldest pending result.
  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;

  assign in_ready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      priority if (skid_v_r) begin
        if (out_ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (in_xfer) begin
        if (out_v_r && !out_ready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (in_xfer) begin
      if (out_v_r && !out_ready) begin
        skid_r <= res_w;
      end else begin
        out_r <= res_w;
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = out_r.status;
  assign out_offending_kind = out_r.offending_kind;
  assign out_line_end       = out_r.line_end;
  assign out_count_round    = out_r.count_round;
  assign out_count_square   = out_r.count_square;
  assign out_count_curly    = out_r.count_curly;
  assign out_count_angle    = out_r.count_angle;
  assign out_total_score    = out_r.total_score;

  // The skid register is only ever filled behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a pending output");

  // The stack level never runs past the memory depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_FULL)
    else $error("stack level beyond depth");

  // A push leaves the pushed kind in the top-of-stack register.
  a_push_tos: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> (tos_r == $past(open_kind)))
    else $error("top of stack lost after push");

  // The score total never decreases between reset pulses.
  a_score_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (score_r >= $past(score_r)))
    else $error("score total decreased");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bracket_nesting_checker_top: drives a byte stream of
// bracket lines and compares every result with an in-bench model of the checker.
// Depends on bnc_pkg and the RTL of bracket_nesting_checker_top.
module tb;
  import bnc_pkg::*;

  // The block is built with its default stack size. The overflow tests rely on
  // this value.
  localparam int unsigned NEST_DEPTH = DEF_STACK_DEPTH;

  // This is the random part of the stream, counted in bytes. Configuration
  // changes fall roughly PHASE_CHARS bytes apart.
  localparam int unsigned RANDOM_CHARS = 1250;
  localparam int unsigned PHASE_CHARS  = 350;

  // Each mode shapes the pattern of the result-side ready signal for a while.
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_LONG_STALL,
    RX_RARE_STALL
  } rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic [KIND_W-1:0]    out_offending_kind;
  logic                 out_line_end;
  logic [COUNT_W-1:0]   out_count_round;
  logic [COUNT_W-1:0]   out_count_square;
  logic [COUNT_W-1:0]   out_count_curly;
  logic [COUNT_W-1:0]   out_count_angle;
  logic [SCORE_W-1:0]   out_total_score;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WEIGHT_W-1:0]  cfg_data;

  // This is the bench's copy of the checker state. It is advanced once per
  // accepted byte.
  kind_t               open_kinds [NEST_DEPTH];
  int unsigned         nest_level;
  bit                  line_skip;
  logic [COUNT_W-1:0]  corrupt_count [4];
  logic [SCORE_W-1:0]  score_total;
  logic [WEIGHT_W-1:0] kind_weight [4];

  // Results that have been predicted but not yet seen on the output, oldest first.
  res_t awaited_results [$];

  int unsigned mismatch_count;
  int unsigned chars_sent;
  int unsigned burst_left;

  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_stall_left;

  bracket_nesting_checker_top #(
    .STACK_DEPTH(NEST_DEPTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_offending_kind(out_offending_kind),
    .out_line_end      (out_line_end),
    .out_count_round   (out_count_round),
    .out_count_square  (out_count_square),
    .out_count_curly   (out_count_curly),
    .out_count_angle   (out_count_angle),
    .out_total_score   (out_total_score),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // This limit is far above the slowest legal run, so only a hung handshake
  // can reach it.
  initial begin
    #4_000_000;
    $display("bracket_nesting_checker_top test failed");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] open_char(kind_t k);
    case (k)
      KIND_ROUND:  return CH_OPEN_ROUND;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] close_char(kind_t k);
    case (k)
      KIND_ROUND:  return CH_CLOSE_ROUND;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  // This computes the result of one byte and advances the model state. A
  // newline always clears the line. Once a line is dead, every byte up to its
  // newline is reported as skipped. A mismatched or unmatched closer scores its
  // kind, with both the counter and the total saturating. An opener that finds
  // the stack full kills the line without a push.
  function automatic res_t next_bracket_result(logic [BYTE_W-1:0] ch);
    res_t  r;
    kind_t k;
    bit    is_open;
    bit    is_close;
    r = '0;
    k = KIND_ROUND;
    is_open = 1'b0;
    is_close = 1'b0;
    case (ch)
      CH_OPEN_ROUND:   begin is_open = 1'b1;  k = KIND_ROUND;  end
      CH_OPEN_SQUARE:  begin is_open = 1'b1;  k = KIND_SQUARE; end
      CH_OPEN_CURLY:   begin is_open = 1'b1;  k = KIND_CURLY;  end
      CH_OPEN_ANGLE:   begin is_open = 1'b1;  k = KIND_ANGLE;  end
      CH_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
      CH_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
      CH_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
      CH_CLOSE_ANGLE:  begin is_close = 1'b1; k = KIND_ANGLE;  end
      default: ;
    endcase
    if (ch == CH_NEWLINE) begin
      r.line_end = 1'b1;
      nest_level = 0;
      line_skip = 1'b0;
    end else if (line_skip) begin
      r.status = ST_SKIPPED;
    end else if (is_open) begin
      if (nest_level >= NEST_DEPTH) begin
        r.status = ST_OVERFLOW;
        line_skip = 1'b1;
      end else begin
        open_kinds[nest_level] = k;
        nest_level++;
      end
    end else if (is_close) begin
      if (nest_level > 0 && open_kinds[nest_level-1] == k) begin
        nest_level--;
      end else begin
        r.status = ST_CORRUPT;
        r.offending_kind = k;
        line_skip = 1'b1;
        if (corrupt_count[k] != COUNT_MAX) corrupt_count[k]++;
        if (score_total > SCORE_MAX - SCORE_W'(kind_weight[k])) score_total = SCORE_MAX;
        else score_total = score_total + SCORE_W'(kind_weight[k]);
      end
    end
    r.count_round  = corrupt_count[KIND_ROUND];
    r.count_square = corrupt_count[KIND_SQUARE];
    r.count_curly  = corrupt_count[KIND_CURLY];
    r.count_angle  = corrupt_count[KIND_ANGLE];
    r.total_score  = score_total;
    return r;
  endfunction

  // This sends one byte. The sender works in bursts. When a burst runs out, a
  // random gap with valid low comes first, and the gap is often zero. Valid stays
  // high from one byte to the next inside a burst, and the prediction is made at
  // the clock edge of the transfer.
  task automatic send_char(input logic [BYTE_W-1:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_byte_in <= ch;
    do @(posedge clk); while (in_ready !== 1'b1);
    awaited_results.push_back(next_bracket_result(ch));
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // This drops valid and waits until every expected result has been seen. It
  // then waits on so that the block is quiet before a register write.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_weight(input reg_idx_t idx, input logic [WEIGHT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    kind_weight[idx] = value;
  endtask

  task automatic write_all_weights(input logic [WEIGHT_W-1:0] value);
    write_weight(REG_WEIGHT_ROUND, value);
    write_weight(REG_WEIGHT_SQUARE, value);
    write_weight(REG_WEIGHT_CURLY, value);
    write_weight(REG_WEIGHT_ANGLE, value);
  endtask

  // This sends one random line. Most lines are well nested with random content.
  // A random closer now and then breaks a line, and some lines are left open.
  // A few lines nest right up to the stack limit or just past it, and a few are
  // plain noise bytes.
  task automatic send_random_line();
    kind_t       open_stack [$];
    kind_t       k;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      len = $urandom_range(1, 30);
      repeat (len) send_char(BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 13) begin
      len = $urandom_range(NEST_DEPTH - 2, NEST_DEPTH + 2);
      repeat (len) begin
        k = kind_t'($urandom_range(0, 3));
        open_stack.push_back(k);
        send_char(open_char(k));
      end
      while (open_stack.size() != 0) send_char(close_char(open_stack.pop_back()));
    end else begin
      len = $urandom_range(1, 40);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          k = kind_t'($urandom_range(0, 3));
          open_stack.push_back(k);
          send_char(open_char(k));
        end else if (pick < 88 && open_stack.size() != 0) begin
          send_char(close_char(open_stack.pop_back()));
        end else if (pick < 94) begin
          k = kind_t'($urandom_range(0, 3));
          send_char(close_char(k));
          if (open_stack.size() != 0 && open_stack[$] == k) void'(open_stack.pop_back());
        end else begin
          send_char(BYTE_W'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        while (open_stack.size() != 0) send_char(close_char(open_stack.pop_back()));
      end
    end
    send_char(CH_NEWLINE);
  endtask

  // Directed lines at the reset weights. The first line closes every kind in
  // order. Then come a closer on an empty stack, mismatches with and without
  // skipped bytes after them, a line left open, and the two extreme byte values.
  task automatic test_directed_lines();
    send_text("([{<>}])\n");
    send_text(")\n");
    send_text("(]");
    send_char(8'hFF);
    send_text("\n");
    send_text("[}\n");
    send_text("{>(\n");
    send_text("<");
    send_char(8'h00);
    send_text("\n");
  endtask

  // The first line fills the stack exactly and then unwinds it, so no overflow
  // may occur. The second line pushes one opener too many. The closer after the
  // overflow must be skipped.
  task automatic test_stack_limit();
    kind_t open_stack [$];
    kind_t k;
    repeat (NEST_DEPTH) begin
      k = kind_t'($urandom_range(0, 3));
      open_stack.push_back(k);
      send_char(open_char(k));
    end
    while (open_stack.size() != 0) send_char(close_char(open_stack.pop_back()));
    send_char(CH_NEWLINE);
    repeat (NEST_DEPTH + 1) send_char(open_char(kind_t'($urandom_range(0, 3))));
    send_char(CH_CLOSE_ROUND);
    send_char(CH_NEWLINE);
  endtask

  // This corrupts every kind with all weights at zero, and round, square and angle
  // with all weights at their maximum. The reset weights are restored at the end.
  task automatic test_weight_extremes();
    wait_idle();
    write_all_weights('0);
    send_text(")\n]\n}\n>\n");
    wait_idle();
    write_all_weights('1);
    send_text("(>\n<]\n[)\n{{}\n");
    wait_idle();
    write_weight(REG_WEIGHT_ROUND, RST_WEIGHT_ROUND);
    write_weight(REG_WEIGHT_SQUARE, RST_WEIGHT_SQUARE);
    write_weight(REG_WEIGHT_CURLY, RST_WEIGHT_CURLY);
    write_weight(REG_WEIGHT_ANGLE, RST_WEIGHT_ANGLE);
  endtask

  // This sends random lines in phases. Between phases the block is drained and
  // each weight gets zero, its maximum, a random value or its reset value.
  task automatic test_random_lines();
    int unsigned     stop_at;
    int unsigned     phase_end;
    logic [WEIGHT_W-1:0] value;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      phase_end = chars_sent + PHASE_CHARS;
      while (chars_sent < phase_end && chars_sent < stop_at) send_random_line();
      wait_idle();
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0:       value = '0;
          1:       value = '1;
          2:       value = WEIGHT_W'($urandom_range(0, 65535));
          default: value = (i == 0) ? RST_WEIGHT_ROUND :
                           (i == 1) ? RST_WEIGHT_SQUARE :
                           (i == 2) ? RST_WEIGHT_CURLY : RST_WEIGHT_ANGLE;
        endcase
        write_weight(reg_idx_t'(i), value);
      end
    end
  endtask

  // The result-side ready follows a pattern that changes mode every so often:
  // always ready, coin flips, long stalls with single-cycle openings, and rare
  // one-cycle stalls.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_LONG_STALL: begin
        if (rx_stall_left != 0) begin
          out_ready <= 1'b0;
          rx_stall_left--;
        end else begin
          out_ready <= 1'b1;
          rx_stall_left = $urandom_range(1, 12);
        end
      end
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch at %0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  // Every result transfer is checked against the oldest prediction, one field
  // at a time. A result that arrives with nothing predicted counts as a failure.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at %0t", $time);
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("offending_kind", want.offending_kind, out_offending_kind);
        compare_field("line_end", want.line_end, out_line_end);
        compare_field("count_round", want.count_round, out_count_round);
        compare_field("count_square", want.count_square, out_count_square);
        compare_field("count_curly", want.count_curly, out_count_curly);
        compare_field("count_angle", want.count_angle, out_count_angle);
        compare_field("total_score", want.total_score, out_total_score);
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte_in = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_WEIGHT_ROUND;
    cfg_data   = '0;
    mismatch_count = 0;
    chars_sent = 0;
    burst_left = 0;
    rx_mode = RX_ALWAYS;
    rx_mode_left = 0;
    rx_stall_left = 0;
    nest_level = 0;
    line_skip = 1'b0;
    score_total = '0;
    foreach (corrupt_count[i]) corrupt_count[i] = '0;
    foreach (open_kinds[i]) open_kinds[i] = KIND_ROUND;
    kind_weight[KIND_ROUND]  = RST_WEIGHT_ROUND;
    kind_weight[KIND_SQUARE] = RST_WEIGHT_SQUARE;
    kind_weight[KIND_CURLY]  = RST_WEIGHT_CURLY;
    kind_weight[KIND_ANGLE]  = RST_WEIGHT_ANGLE;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_stack_limit();
    test_weight_extremes();
    test_random_lines();

    // Results that are still expected after the drain are failures as well.
    wait_idle();
    repeat (10) @(posedge clk);
    mismatch_count += awaited_results.size();
    if (mismatch_count == 0) begin
      $display("bracket_nesting_checker_top test passed");
    end else begin
      $display("bracket_nesting_checker_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bnc_pkg.sv
rtl/core/bracket_nesting_checker_top.sv
bench/tb.sv
